>>> sv/bfss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfss_pkg;

  // Default size of the byte store.
  localparam int STORE_BYTES_DEF = 4096;

  // Fixed field widths.
  localparam int FIELD_W   = 64;
  localparam int COUNT_W   = 7;
  localparam int BIT_W     = 3;
  localparam int BYTE_W    = 8;
  localparam int SKIP_W    = 16;
  localparam int SEEK_W    = 13;
  localparam int STATUS_W  = 2;
  localparam int USED_W    = 13;

  // Memory organisation: rows of sixteen bytes, even and odd rows in two banks.
  localparam int ROW_BYTES = 16;
  localparam int ROW_W     = ROW_BYTES * BYTE_W;
  localparam int WIN_BYTES = 9;
  localparam int WIN_W     = WIN_BYTES * BYTE_W;
  localparam int PAIR_BYTES = 2 * ROW_BYTES;

  typedef enum logic [2:0] {
    MODE_WRITE  = 3'd0,
    MODE_PEEK   = 3'd1,
    MODE_SKIP   = 3'd2,
    MODE_SEEK   = 3'd3,
    MODE_ALIGN  = 3'd4,
    MODE_REWIND = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_OVERRUN   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // Controls handed from the command stage to the window datapath.
  typedef struct packed {
    logic                 do_write;
    logic                 do_peek;
    logic                 swap;
    logic [COUNT_W-1:0]   bits;
    logic [BIT_W-1:0]     shift;
    logic [3:0]           offset;
    logic [WIN_BYTES-1:0] byte_ok;
  } win_cmd_t;

  function automatic logic [FIELD_W-1:0] field_mask(input logic [COUNT_W-1:0] bits);
    logic [FIELD_W-1:0] m;
    if (bits >= COUNT_W'(FIELD_W)) begin
      m = '1;
    end else begin
      m = (FIELD_W'(1) << bits) - FIELD_W'(1);
    end
    return m;
  endfunction

  // Byte-reverses the lowest ceil(bits/8) bytes when swap is set and the field is wider than a byte.
  function automatic logic [FIELD_W-1:0] order_fix(input logic [FIELD_W-1:0] v,
                                                   input logic [COUNT_W-1:0] bits,
                                                   input logic swap);
    logic [FIELD_W-1:0] r;
    logic [3:0]         n;
    r = v;
    n = 4'((bits + COUNT_W'(7)) >> 3);
    if (swap && (bits > COUNT_W'(BYTE_W))) begin
      r = '0;
      for (int j = 0; j < FIELD_W / BYTE_W; j++) begin
        for (int i = 0; i < FIELD_W / BYTE_W; i++) begin
          if ((j < int'(n)) && (i + j == int'(n) - 1)) begin
            r[BYTE_W*j +: BYTE_W] = v[BYTE_W*i +: BYTE_W];
          end
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/bfss_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module bfss_mem #(
  parameter int AW = 7
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             addr,
  input  wire logic [bfss_pkg::ROW_BYTES-1:0] be,
  input  wire logic [bfss_pkg::ROW_W-1:0]     wdata,
  output logic      [bfss_pkg::ROW_W-1:0]     rdata
);
  import bfss_pkg::*;

  logic [ROW_W-1:0] mem [2**AW];

  // One row per access; the read data is registered and holds while idle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        for (int i = 0; i < ROW_BYTES; i++) begin
          if (be[i]) begin
            mem[addr][BYTE_W*i +: BYTE_W] <= wdata[BYTE_W*i +: BYTE_W];
          end
        end
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/bfss_window.sv
`timescale 1ns / 1ps
`default_nettype none

module bfss_window (
  input  wire bfss_pkg::win_cmd_t             cmd,
  input  wire logic [bfss_pkg::WIN_W-1:0]     wfield,
  input  wire logic [bfss_pkg::ROW_W-1:0]     lo_rd,
  input  wire logic [bfss_pkg::ROW_W-1:0]     hi_rd,
  output logic      [bfss_pkg::ROW_W-1:0]     lo_wd,
  output logic      [bfss_pkg::ROW_W-1:0]     hi_wd,
  output logic      [bfss_pkg::ROW_BYTES-1:0] lo_be,
  output logic      [bfss_pkg::ROW_BYTES-1:0] hi_be,
  output logic      [bfss_pkg::FIELD_W-1:0]   peek_value
);
  import bfss_pkg::*;

  logic [2*ROW_W-1:0]      rd;
  logic [2*ROW_W-1:0]      wd;
  logic [PAIR_BYTES-1:0]   be;
  logic [WIN_W-1:0]        win;
  logic [FIELD_W-1:0]      shifted;

  // The nine-byte window starts at the cursor's byte offset within the row pair.
  always_comb begin
    rd  = {hi_rd, lo_rd};
    wd  = rd;
    be  = '0;
    win = '0;
    for (int k = 0; k < WIN_BYTES; k++) begin
      if (cmd.byte_ok[k]) begin
        win[BYTE_W*k +: BYTE_W] = rd[BYTE_W*(int'(cmd.offset) + k) +: BYTE_W];
        wd[BYTE_W*(int'(cmd.offset) + k) +: BYTE_W] =
          rd[BYTE_W*(int'(cmd.offset) + k) +: BYTE_W] | wfield[BYTE_W*k +: BYTE_W];
        be[int'(cmd.offset) + k] = cmd.do_write;
      end
    end
    shifted = FIELD_W'(win >> cmd.shift);
    if (cmd.do_peek) begin
      peek_value = order_fix(shifted & field_mask(cmd.bits), cmd.bits, cmd.swap);
    end else begin
      peek_value = '0;
    end
  end

  assign lo_wd = wd[ROW_W-1:0];
  assign hi_wd = wd[2*ROW_W-1:ROW_W];
  assign lo_be = be[ROW_BYTES-1:0];
  assign hi_be = be[PAIR_BYTES-1:ROW_BYTES];

endmodule

`default_nettype wire

>>> sv/bit_field_stream_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Direction  Carries
// in        in_valid / in_stall    into block mode, write_value, bit_count, skip_bits,
//                                             seek_byte, seek_bit
// out       out_valid / out_stall  out        read_value, status, bytes_used
// cfg       cfg_valid / cfg_ready  into block big_endian
//
// Each item is accepted in the idle state, where the two-row window is read from the
// even and odd row banks; the execute state that follows merges, writes back and
// loads the result register. The banks' registered read data is why the work is split.
// After reset the banks are cleared one row pair per cycle, through all 2**AW pairs (128 for
// the default 4096-byte store), while in_stall is held high.
// A stalled result holds the block in its execute cycle until the result is taken.

module bit_field_stream_store #(
  parameter int STORE_BYTES = bfss_pkg::STORE_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [2:0]                      mode,
  input  wire logic [bfss_pkg::FIELD_W-1:0]    write_value,
  input  wire logic [bfss_pkg::COUNT_W-1:0]    bit_count,
  input  wire logic [bfss_pkg::SKIP_W-1:0]     skip_bits,
  input  wire logic [bfss_pkg::SEEK_W-1:0]     seek_byte,
  input  wire logic [bfss_pkg::BIT_W-1:0]      seek_bit,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [bfss_pkg::FIELD_W-1:0]         read_value,
  output logic [bfss_pkg::STATUS_W-1:0]        status,
  output logic [bfss_pkg::USED_W-1:0]          bytes_used,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic                            big_endian
);
  import bfss_pkg::*;

  // Cursor byte runs from 0 to STORE_BYTES inclusive.
  localparam int CBW   = $clog2(STORE_BYTES + 1);
  localparam int PW    = CBW + BIT_W;
  localparam int XW    = ((PW > SKIP_W) ? PW : SKIP_W) + 2;
  localparam int RW    = CBW - 4;
  localparam int ROWS  = (STORE_BYTES + ROW_BYTES - 1) / ROW_BYTES;
  localparam int EROWS = (ROWS + 1) / 2;
  localparam int AW    = (EROWS > 1) ? $clog2(EROWS) : 1;
  localparam logic [XW-1:0] STORE_BITS = XW'(STORE_BYTES * 8);
  localparam logic [XW-1:0] MAX_POS    = XW'(STORE_BYTES * 8 + 7);

  state_t state;
  state_t state_next;

  logic [CBW-1:0]     cursor_byte;
  logic [BIT_W-1:0]   cursor_bit;
  logic               swap_mode;
  logic [AW-1:0]      clr_addr;

  win_cmd_t           cmd;
  win_cmd_t           cmd_next;
  logic [WIN_W-1:0]   wfield;
  logic [WIN_W-1:0]   wfield_next;
  logic [PW-1:0]      pend_pos;
  logic [PW-1:0]      pend_pos_next;
  status_t            pend_status;
  status_t            pend_status_next;

  logic               accept;
  logic               go;

  logic [XW-1:0]      pos_ext;
  logic [XW-1:0]      raw_pos;
  logic               bad_count;
  logic [FIELD_W-1:0] fixed_value;

  logic [RW:0]        row_ext;
  logic [RW:0]        even_row;
  logic [RW:0]        odd_row;
  logic               row_odd;

  logic               mem_en;
  logic               mem_we;
  logic [AW-1:0]      even_addr;
  logic [AW-1:0]      odd_addr;
  logic [ROW_W-1:0]   even_rd;
  logic [ROW_W-1:0]   odd_rd;
  logic [ROW_W-1:0]   even_wd;
  logic [ROW_W-1:0]   odd_wd;
  logic [ROW_BYTES-1:0] even_be;
  logic [ROW_BYTES-1:0] odd_be;

  logic [ROW_W-1:0]   lo_rd;
  logic [ROW_W-1:0]   hi_rd;
  logic [ROW_W-1:0]   lo_wd;
  logic [ROW_W-1:0]   hi_wd;
  logic [ROW_BYTES-1:0] lo_be;
  logic [ROW_BYTES-1:0] hi_be;
  logic [FIELD_W-1:0] peek_value;

  // Items are taken only in the idle state; configuration is always welcome, but it must
  // only arrive while the block has nothing in flight; the block itself does not enforce this.
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign go        = (state == S_EXEC) && (!out_valid || !out_stall);
  assign cfg_ready = 1'b1;

  // The window covers the cursor's row and the next one. Rows alternate between the
  // even and the odd bank, so both rows are read in the same cycle.
  assign row_ext  = {1'b0, cursor_byte[CBW-1:4]};
  assign even_row = (row_ext + (RW+1)'(1)) >> 1;
  assign odd_row  = row_ext >> 1;
  assign row_odd  = cursor_byte[4];

  assign lo_rd = row_odd ? odd_rd : even_rd;
  assign hi_rd = row_odd ? even_rd : odd_rd;

  // Command decode at the accept cycle: status, the cursor that follows, and the
  // write field already masked, byte-ordered and shifted to the bit index.
  always_comb begin
    pos_ext     = XW'({cursor_byte, cursor_bit});
    bad_count   = (bit_count == '0) || (bit_count > COUNT_W'(FIELD_W));
    fixed_value = order_fix(write_value & field_mask(bit_count), bit_count, swap_mode);
    raw_pos     = pos_ext;
    pend_status_next = ST_OK;
    cmd_next.do_write = 1'b0;
    cmd_next.do_peek  = 1'b0;
    cmd_next.swap     = swap_mode;
    cmd_next.bits     = bit_count;
    cmd_next.shift    = cursor_bit;
    cmd_next.offset   = cursor_byte[3:0];
    for (int k = 0; k < WIN_BYTES; k++) begin
      cmd_next.byte_ok[k] = (XW'(cursor_byte) + XW'(k)) < XW'(STORE_BYTES);
    end
    wfield_next = WIN_W'({8'b0, fixed_value}) << cursor_bit;

    case (mode)
      MODE_WRITE: begin
        if (bad_count) begin
          pend_status_next = ST_BAD_COUNT;
        end else if (pos_ext + XW'(bit_count) > STORE_BITS) begin
          pend_status_next = ST_OVERRUN;
        end else begin
          cmd_next.do_write = 1'b1;
          raw_pos = pos_ext + XW'(bit_count);
        end
      end
      MODE_PEEK: begin
        if (bad_count) begin
          pend_status_next = ST_BAD_COUNT;
        end else begin
          cmd_next.do_peek = 1'b1;
        end
      end
      MODE_SKIP:   raw_pos = pos_ext + XW'(skip_bits);
      MODE_SEEK:   raw_pos = XW'({seek_byte, seek_bit});
      MODE_ALIGN: begin
        if (cursor_bit != '0) begin
          raw_pos = (XW'(cursor_byte) + XW'(1)) << BIT_W;
        end
      end
      MODE_REWIND: raw_pos = '0;
      default:     raw_pos = pos_ext;
    endcase

    // The cursor saturates at the last bit of byte STORE_BYTES.
    if (raw_pos > MAX_POS) begin
      pend_pos_next = PW'(MAX_POS);
    end else begin
      pend_pos_next = PW'(raw_pos);
    end
  end

  // Bank port control: the clearing sweep, the window read on accept and the
  // write-back when the execute cycle completes.
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    even_addr = even_row[AW-1:0];
    odd_addr  = odd_row[AW-1:0];
    even_wd   = row_odd ? hi_wd : lo_wd;
    odd_wd    = row_odd ? lo_wd : hi_wd;
    even_be   = row_odd ? hi_be : lo_be;
    odd_be    = row_odd ? lo_be : hi_be;
    unique case (state)
      S_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        even_addr = clr_addr;
        odd_addr  = clr_addr;
        even_wd   = '0;
        odd_wd    = '0;
        even_be   = '1;
        odd_be    = '1;
      end
      S_IDLE: begin
        mem_en = accept;
      end
      S_EXEC: begin
        mem_en = go && cmd.do_write;
        mem_we = 1'b1;
      end
      default: begin
        mem_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (&clr_addr) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      cursor_byte <= '0;
      cursor_bit  <= '0;
      swap_mode   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        swap_mode <= big_endian;
      end
      if (go) begin
        cursor_byte <= pend_pos[PW-1:BIT_W];
        cursor_bit  <= pend_pos[BIT_W-1:0];
        out_valid   <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd         <= cmd_next;
      wfield      <= wfield_next;
      pend_pos    <= pend_pos_next;
      pend_status <= pend_status_next;
    end
    if (go) begin
      read_value <= peek_value;
      status     <= pend_status;
      bytes_used <= USED_W'(pend_pos[PW-1:BIT_W]) + USED_W'(|pend_pos[BIT_W-1:0]);
    end
  end

  bfss_mem #(
    .AW(AW)
  ) u_even (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (even_addr),
    .be    (even_be),
    .wdata (even_wd),
    .rdata (even_rd)
  );

  bfss_mem #(
    .AW(AW)
  ) u_odd (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (odd_addr),
    .be    (odd_be),
    .wdata (odd_wd),
    .rdata (odd_rd)
  );

  bfss_window u_window (
    .cmd        (cmd),
    .wfield     (wfield),
    .lo_rd      (lo_rd),
    .hi_rd      (hi_rd),
    .lo_wd      (lo_wd),
    .hi_wd      (hi_wd),
    .lo_be      (lo_be),
    .hi_be      (hi_be),
    .peek_value (peek_value)
  );

  // An accepted item always moves the block into its execute cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted item did not enter execute");

  // A new result only appears straight after an execute cycle.
  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("result appeared without execute");

  // The banks are never written while items are being accepted.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (mem_en && mem_we) |-> (state != S_IDLE))
    else $error("bank write in idle state");

  // The cursor never passes the saturation point.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    XW'({cursor_byte, cursor_bit}) <= MAX_POS)
    else $error("cursor beyond store limit");

  // The cursor only moves when an item completes.
  a_cursor_hold: assert property (@(posedge clk) disable iff (rst)
    !go |=> ($stable(cursor_byte) && $stable(cursor_bit)))
    else $error("cursor moved without a completing item");

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

// Bench for the bit-addressed byte store. A tracker object keeps its own copy of the
// store, the cursor and the byte-order setting. For every command the block accepts,
// it works out the result that the block should return. Results are checked in order,
// field by field. Stimulus opens with a short directed run through every command and
// the corner cases. It then runs bursts of seek, write, seek back and peek with random
// widths and values, mixed with stray commands. The byte order is changed between
// phases, and both sides of the block idle at random.

module testbench;
  import bfss_pkg::*;

  localparam int STORE        = STORE_BYTES_DEF;
  localparam int STORE_BITS   = STORE * 8;
  // The cursor saturates at byte STORE, bit 7.
  localparam int LAST_POS     = STORE_BITS + 7;
  localparam int RANDOM_ITEMS = 850;
  localparam int PHASE_ITEMS  = 140;
  // Cycles without any handshake before the run is declared hung. The slowest
  // correct stretch is the clearing pass after reset, otherwise the idle gap on the
  // sending side, the work of the block and the stall on the result side for an item,
  // so this leaves a wide margin.
  localparam int QUIET_LIMIT  = 2000;

  typedef struct {
    logic [2:0]         mode;
    logic [FIELD_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic [SKIP_W-1:0]  skip;
    logic [SEEK_W-1:0]  sbyte;
    logic [BIT_W-1:0]   sbit;
  } command_t;

  typedef struct {
    logic [FIELD_W-1:0]  data;
    logic [STATUS_W-1:0] status;
    logic [USED_W-1:0]   used;
  } field_result_t;

  // Tracks the store contents and the cursor. It predicts one result for every
  // accepted command and checks the results that the block returns against them.
  class field_store_tracker;
    logic [BYTE_W-1:0] store_bytes [STORE];
    int unsigned       cursor;
    bit                swap;
    field_result_t     awaited [$];
    int unsigned       failures;

    function new();
      foreach (store_bytes[i]) begin
        store_bytes[i] = '0;
      end
      cursor   = 0;
      swap     = 1'b0;
      failures = 0;
    endfunction

    function void note_failure(string msg);
      failures++;
      $display("%0t: %s", $time, msg);
    endfunction

    function void move_to(int unsigned target);
      cursor = (target > LAST_POS) ? LAST_POS : target;
    endfunction

    function logic [FIELD_W-1:0] low_ones(int unsigned width);
      return (width >= FIELD_W) ? '1 : ((FIELD_W'(1) << width) - FIELD_W'(1));
    endfunction

    // In big-endian mode a field wider than one byte has its bytes reversed.
    function logic [FIELD_W-1:0] byte_flip(logic [FIELD_W-1:0] v, int width);
      logic [FIELD_W-1:0] r;
      int                 nb;
      if (!swap || width <= 8) begin
        return v;
      end
      nb = (width + 7) / 8;
      r  = '0;
      for (int k = 0; k < nb; k++) begin
        r[8*(nb-1-k) +: 8] = v[8*k +: 8];
      end
      return r;
    endfunction

    function void take_command(input command_t c);
      field_result_t      r;
      logic [FIELD_W-1:0] field;
      logic [WIN_W-1:0]   window;
      int unsigned        first;
      int unsigned        shift;
      int                 width;
      first    = cursor / 8;
      shift    = cursor % 8;
      width    = c.count;
      r.data   = '0;
      r.status = ST_OK;
      case (c.mode)
        MODE_WRITE, MODE_PEEK: begin
          if (width == 0 || width > FIELD_W) begin
            r.status = ST_BAD_COUNT;
          end else if (c.mode == MODE_WRITE) begin
            if (cursor + width > STORE_BITS) begin
              r.status = ST_OVERRUN;
            end else begin
              // The flipped field may carry bits above its width. They are ORed in
              // too, except where they fall beyond the store.
              field  = byte_flip(c.value & low_ones(width), width);
              window = WIN_W'(field) << shift;
              for (int i = 0; i < WIN_BYTES; i++) begin
                if (first + i < STORE) begin
                  store_bytes[first + i] |= window[8*i +: 8];
                end
              end
              move_to(cursor + width);
            end
          end else begin
            // Bytes beyond the store read as zero.
            window = '0;
            for (int i = 0; i < WIN_BYTES; i++) begin
              if (first + i < STORE) begin
                window[8*i +: 8] = store_bytes[first + i];
              end
            end
            field  = FIELD_W'(window >> shift);
            r.data = byte_flip(field & low_ones(width), width);
          end
        end
        MODE_SKIP: begin
          move_to(cursor + c.skip);
        end
        MODE_SEEK: begin
          move_to(c.sbyte * 8 + c.sbit);
        end
        MODE_ALIGN: begin
          if (shift != 0) begin
            move_to((first + 1) * 8);
          end
        end
        MODE_REWIND: begin
          cursor = 0;
        end
        default: begin
          // The two unused codes leave everything as it is.
        end
      endcase
      r.used = USED_W'(cursor / 8 + ((cursor % 8 != 0) ? 1 : 0));
      awaited.push_back(r);
    endfunction

    function void match_result(logic [FIELD_W-1:0] got_data, logic [STATUS_W-1:0] got_status,
                               logic [USED_W-1:0] got_used);
      field_result_t want;
      if (awaited.size() == 0) begin
        note_failure($sformatf("result with no command outstanding: %h status %0d used %0d",
                               got_data, got_status, got_used));
        return;
      end
      want = awaited.pop_front();
      if (got_data !== want.data) begin
        note_failure($sformatf("read_value expected %h, got %h", want.data, got_data));
      end
      if (got_status !== want.status) begin
        note_failure($sformatf("status expected %0d, got %0d", want.status, got_status));
      end
      if (got_used !== want.used) begin
        note_failure($sformatf("bytes_used expected %0d, got %0d", want.used, got_used));
      end
    endfunction

    function void report_leftovers();
      while (awaited.size() != 0) begin
        note_failure($sformatf("result never returned: expected %h status %0d used %0d",
                               awaited[0].data, awaited[0].status, awaited[0].used));
        void'(awaited.pop_front());
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [2:0]          mode;
  logic [FIELD_W-1:0]  write_value;
  logic [COUNT_W-1:0]  bit_count;
  logic [SKIP_W-1:0]   skip_bits;
  logic [SEEK_W-1:0]   seek_byte;
  logic [BIT_W-1:0]    seek_bit;
  logic                out_valid;
  logic                out_stall;
  logic [FIELD_W-1:0]  read_value;
  logic [STATUS_W-1:0] status;
  logic [USED_W-1:0]   bytes_used;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                big_endian;

  field_store_tracker tracker = new();

  // Whether each side draws idle cycles in the current phase; some phases run flat out.
  bit          idle_in = 1'b1;
  bit          idle_out = 1'b1;
  int unsigned commands_taken = 0;
  int unsigned last_anchor = 0;

  bit_field_stream_store dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .write_value (write_value),
    .bit_count   (bit_count),
    .skip_bits   (skip_bits),
    .seek_byte   (seek_byte),
    .seek_bit    (seek_bit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .status      (status),
    .bytes_used  (bytes_used),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .big_endian  (big_endian)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Every field gets a random value, so that the fields a command ignores still see
  // all their bits toggle.
  function automatic command_t scrambled();
    command_t c;
    c.mode  = 3'($urandom_range(0, 7));
    c.value = {$urandom, $urandom};
    c.count = COUNT_W'($urandom);
    c.skip  = SKIP_W'($urandom);
    c.sbyte = SEEK_W'($urandom);
    c.sbit  = BIT_W'($urandom);
    return c;
  endfunction

  function automatic command_t op(logic [2:0] m, logic [FIELD_W-1:0] v,
                                  logic [COUNT_W-1:0] n, logic [SKIP_W-1:0] s);
    command_t c;
    c.mode  = m;
    c.value = v;
    c.count = n;
    c.skip  = s;
    c.sbyte = '0;
    c.sbit  = '0;
    return c;
  endfunction

  function automatic command_t seek_to(int unsigned pos);
    command_t c;
    c       = scrambled();
    c.mode  = MODE_SEEK;
    c.sbyte = SEEK_W'(pos / 8);
    c.sbit  = BIT_W'(pos % 8);
    return c;
  endfunction

  // Field widths are mostly legal; about one in twelve is zero or above 64.
  function automatic logic [COUNT_W-1:0] pick_width();
    if ($urandom_range(0, 11) == 0) begin
      return ($urandom_range(0, 1) == 0) ? '0 : COUNT_W'($urandom_range(65, 127));
    end
    return COUNT_W'($urandom_range(1, 64));
  endfunction

  function automatic command_t field_cmd(logic [2:0] m, logic [COUNT_W-1:0] width);
    command_t c;
    c       = scrambled();
    c.mode  = m;
    c.count = width;
    return c;
  endfunction

  // A stray command that breaks up the write and read-back pattern.
  function automatic command_t stray_cmd();
    command_t c;
    c = scrambled();
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        c.mode = MODE_SKIP;
        if ($urandom_range(0, 3) != 0) begin
          c.skip = SKIP_W'($urandom_range(0, 200));
        end
      end
      3: c.mode = MODE_SEEK;
      4, 9: c.mode = MODE_ALIGN;
      5: c.mode = MODE_REWIND;
      6: c.mode = 3'($urandom_range(6, 7));
      7: c = field_cmd(MODE_PEEK, pick_width());
      default: c.mode = MODE_WRITE;
    endcase
    return c;
  endfunction

  // Presents one item and returns at the edge where it is taken. The valid stays high
  // on return, so a caller either presents the next item in the same step or lowers it.
  task automatic send(input command_t c);
    int unsigned gap;
    gap = idle_in ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= c.mode;
    write_value <= c.value;
    bit_count   <= c.count;
    skip_bits   <= c.skip;
    seek_byte   <= c.sbyte;
    seek_bit    <= c.sbit;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.take_command(c);
    if (c.mode <= MODE_REWIND) begin
      commands_taken++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.awaited.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // The byte order only changes once every result is back, so the block is idle.
  task automatic set_order(input logic be);
    drain();
    cfg_valid  <= 1'b1;
    big_endian <= be;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.swap = be;
    cfg_valid <= 1'b0;
  endtask

  // One well-formed burst: seek to an anchor, write a few fields, seek back and peek
  // them again, mostly with the same widths. The anchor is anywhere in the store, near
  // its end, or the previous anchor, so that new fields are ORed over old ones.
  task automatic run_burst();
    int unsigned        anchor;
    int unsigned        fields;
    int unsigned        pick;
    logic [COUNT_W-1:0] widths [8];
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      anchor = $urandom_range(0, STORE_BITS - 1);
    end else if (pick < 8) begin
      anchor = $urandom_range(STORE_BITS - 96, LAST_POS);
    end else begin
      anchor = last_anchor;
    end
    last_anchor = anchor;
    fields = $urandom_range(1, 6);
    send(seek_to(anchor));
    for (int i = 0; i < fields; i++) begin
      widths[i] = pick_width();
      send(field_cmd(MODE_WRITE, widths[i]));
      if ($urandom_range(0, 7) == 0) begin
        send(stray_cmd());
      end
    end
    send(seek_to(anchor));
    for (int i = 0; i < fields; i++) begin
      send(field_cmd(MODE_PEEK, ($urandom_range(0, 3) == 0) ? pick_width() : widths[i]));
      if ($urandom_range(0, 1) == 0) begin
        // Step over the field just read, as a reader of the stream would.
        send(op(MODE_SKIP, '0, '0, SKIP_W'(widths[i])));
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      send(stray_cmd());
    end
  endtask

  initial begin
    int          phase;
    int unsigned phase_end;
    command_t    c;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    mode        <= '0;
    write_value <= '0;
    bit_count   <= '0;
    skip_bits   <= '0;
    seek_byte   <= '0;
    seek_bit    <= '0;
    cfg_valid   <= 1'b0;
    big_endian  <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, little-endian first.
    set_order(1'b0);
    send(op(MODE_WRITE, 64'hFEDC_BA98_7654_3210, 7'd64, '0));
    send(op(MODE_WRITE, '1, 7'd1, '0));
    send(op(MODE_WRITE, 64'h1234_5678_9ABC_DEF0, 7'd13, '0));
    // Bad bit counts: zero, far above 64 and just above.
    send(op(MODE_WRITE, '1, 7'd0, '0));
    send(op(MODE_PEEK, '0, 7'd127, '0));
    send(op(MODE_WRITE, '1, 7'd65, '0));
    send(op(MODE_REWIND, '0, '0, '0));
    send(op(MODE_PEEK, '0, 7'd64, '0));
    send(op(MODE_SKIP, '0, '0, 16'd67));
    send(op(MODE_PEEK, '0, 7'd12, '0));
    send(op(MODE_ALIGN, '0, '0, '0));
    // The cursor saturates at the end, and a write there overruns.
    send(op(MODE_SKIP, '0, '0, '1));
    send(op(MODE_ALIGN, '0, '0, '0));
    send(op(MODE_WRITE, '1, 7'd1, '0));
    // A byte that ends exactly on the last bit fits; one bit further does not.
    send(seek_to(STORE_BITS - 8));
    send(op(MODE_WRITE, 64'hA5, 7'd8, '0));
    send(seek_to(STORE_BITS - 7));
    send(op(MODE_WRITE, '1, 7'd8, '0));
    // A peek that runs off the end reads zeros.
    send(seek_to(STORE_BITS - 29));
    send(op(MODE_PEEK, '0, 7'd64, '0));
    send(op(3'd6, '1, 7'd64, '1));
    send(op(3'd7, '1, 7'd64, '1));
    c       = op(MODE_SEEK, '0, '0, '0);
    c.sbyte = '1;
    c.sbit  = '1;
    send(c);

    // Big-endian: multi-byte fields are reversed, and a reversed short field spills
    // above its width, beyond the store when written at the very end.
    set_order(1'b1);
    send(seek_to(805));
    send(op(MODE_WRITE, 64'h0123_4567_89AB_CDEF, 7'd64, '0));
    send(op(MODE_WRITE, 64'hFFFF_FFFF_FFFF_F1FF, 7'd9, '0));
    send(seek_to(805));
    send(op(MODE_PEEK, '0, 7'd64, '0));
    send(seek_to(869));
    send(op(MODE_PEEK, '0, 7'd9, '0));
    send(seek_to(STORE_BITS - 9));
    send(op(MODE_WRITE, '1, 7'd9, '0));
    send(seek_to(STORE_BITS - 9));
    send(op(MODE_PEEK, '0, 7'd17, '0));

    // Random part, in phases with alternating byte order and different idling.
    commands_taken = 0;
    phase = 0;
    while (commands_taken < RANDOM_ITEMS) begin
      set_order(phase[0]);
      idle_in   = (phase % 3 != 2);
      idle_out  = (phase % 4 != 3);
      phase_end = commands_taken + PHASE_ITEMS;
      while (commands_taken < phase_end && commands_taken < RANDOM_ITEMS) begin
        run_burst();
      end
      phase++;
    end

    drain();
    repeat (10) @(posedge clk);
    tracker.report_leftovers();
    if (tracker.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: where idle_out is set, stalls for a random number of cycles before each result, then takes it.
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      hold = idle_out ? $urandom_range(0, 9) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.match_result(read_value, status, bytes_used);
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule
